// ===== hw/rtl/svapr_pkg.sv =====
// Shared constants, operation codes and control types for the servo and audio receiver.
package svapr_pkg;

  // Operation codes carried by the operation field.
  localparam logic [2:0] OP_SERVO = 3'd0;
  localparam logic [2:0] OP_AUDIO_START = 3'd1;
  localparam logic [2:0] OP_FRAGMENT = 3'd2;
  localparam logic [2:0] OP_PLAY = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  // Status codes reported with every result.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_DROPPED = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  // Bytes per fragment slot in the sample store.
  localparam int unsigned CHUNK_BYTES = 200;

  // Servo mapping: pulse = 500 + (angle + 90) * 2000 / 180.
  localparam logic signed [15:0] ANGLE_MIN = -16'sd90;
  localparam logic signed [15:0] ANGLE_MAX = 16'sd90;
  localparam logic [11:0] PULSE_MIN = 12'd500;
  localparam logic [11:0] PULSE_CENTER = 12'd1500;
  // Ceiling of 100 * 2^24 / 9; exact truncating divide for offsets 0..180.
  localparam logic [27:0] PULSE_RECIP = 28'd186413512;
  localparam int unsigned PULSE_SHIFT = 24;

  localparam logic [7:0] DUTY_IDLE = 8'd128;
  localparam logic [16:0] LIMIT_RESET = 17'd40000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_duty;
    logic load_out;
  } svapr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sample_fetch;
  } svapr_stat_t;

endpackage

// ===== hw/rtl/svapr_ctrl.sv =====
// Controller state machine that sequences each item through the datapath.
module svapr_ctrl
  import svapr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  svapr_stat_t stat,
  output svapr_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  // Commands follow directly from the state and the handshake signals.
  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.capture = in_valid && (state == S_IDLE);
    cmd.execute = (state == S_EXEC);
    cmd.load_duty = (state == S_FETCH);
    cmd.load_out = (state == S_DONE) && (!out_valid || out_ready);
  end

  // Next state: a tick that plays a sample passes through the fetch state for the store read.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = stat.sample_fetch ? S_FETCH : S_DONE;
      end
      S_FETCH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The output register is full from its load until the item is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  // An accepted item always goes straight to execution.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted item did not enter execution");

  // Execution of a playing tick always enters the store read.
  a_fetch_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && stat.sample_fetch) |=> (state == S_FETCH))
    else $error("sample fetch skipped");

  // A finished item waits while the previous result is still held.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result overwritten before it was taken");

  // The fetch state is always followed by the done state.
  a_fetch_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |=> (state == S_DONE))
    else $error("fetch state did not finish");
`endif

endmodule

// ===== hw/rtl/svapr_dpath.sv =====
// Datapath: input register, receiver state, sample store and result register.
module svapr_dpath
  import svapr_pkg::*;
#(
  parameter int STORE_DEPTH = 65536
)
(
  input  logic                clk,
  input  logic                rst,
  input  svapr_cmd_t          cmd,
  output svapr_stat_t         stat,
  input  logic                cfg_write,
  input  logic [16:0]         cfg_data,
  input  logic [2:0]          operation,
  input  logic signed [15:0]  first_angle,
  input  logic signed [15:0]  second_angle,
  input  logic [31:0]         announced_samples,
  input  logic [15:0]         announced_fragments,
  input  logic [15:0]         fragment_number,
  input  logic [7:0]          fragment_length,
  input  logic [7:0]          byte_position,
  input  logic [7:0]          sample_byte,
  input  logic                fragment_end,
  output logic [11:0]         first_pulse,
  output logic [11:0]         second_pulse,
  output logic [7:0]          speaker_duty,
  output logic                is_playing,
  output logic                audio_complete,
  output logic [1:0]          status
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(STORE_DEPTH);

  // Captured item.
  logic [2:0]         op_q;
  logic signed [15:0] angle1_q;
  logic signed [15:0] angle2_q;
  logic [31:0]        ann_samples_q;
  logic [15:0]        ann_frags_q;
  logic [15:0]        frag_num_q;
  logic [7:0]         frag_len_q;
  logic [7:0]         byte_pos_q;
  logic [7:0]         sample_q;
  logic               frag_end_q;

  // Receiver state.
  logic [16:0] sample_limit;
  logic [16:0] stored_count;
  logic [15:0] expected_count;
  logic [15:0] received_count;
  logic        ready_flag;
  logic        playing_flag;
  logic [16:0] play_position;
  logic [16:0] play_length;
  logic [11:0] pulse_one;
  logic [11:0] pulse_two;
  logic [7:0]  duty_value;
  logic [1:0]  status_q;

  logic [7:0] sample_store [STORE_DEPTH];
  logic [7:0] rd_data;

  // Combinational helpers.
  logic [16:0]        lim;
  logic [16:0]        clamped_count;
  logic [23:0]        frag_base;
  logic [24:0]        frag_end_sum;
  logic               frag_ok;
  logic               store_write;
  logic [AW-1:0]      wr_addr;
  logic [15:0]        received_inc;
  logic               play_ok;
  logic               tick_has_sample;
  logic signed [15:0] clamp1;
  logic signed [15:0] clamp2;
  logic [7:0]         offset1;
  logic [7:0]         offset2;
  logic [35:0]        prod1;
  logic [35:0]        prod2;
  logic [11:0]        pulse1_calc;
  logic [11:0]        pulse2_calc;

  // Limit in force is the smaller of the register and the store depth; the announced count is clamped to it.
  always_comb begin
    lim = (32'(sample_limit) < DEPTH_W) ? sample_limit : 17'(STORE_DEPTH);
    clamped_count = (ann_samples_q < 32'(lim)) ? ann_samples_q[16:0] : lim;
  end

  // Fragment placement and range check.
  always_comb begin
    frag_base = 24'(frag_num_q) * 24'(CHUNK_BYTES);
    frag_end_sum = 25'(frag_base) + 25'(frag_len_q);
    frag_ok = (frag_len_q <= 8'(CHUNK_BYTES)) && (frag_end_sum <= 25'(lim));
    wr_addr = AW'(frag_base + 24'(byte_pos_q));
    store_write = cmd.execute && (op_q == OP_FRAGMENT) && frag_ok
                  && (byte_pos_q < frag_len_q);
    received_inc = received_count + 16'd1;
  end

  // Play and tick conditions.
  always_comb begin
    play_ok = ready_flag && (stored_count != 17'd0);
    tick_has_sample = playing_flag && (play_position < play_length);
    stat.sample_fetch = (op_q == OP_TICK) && tick_has_sample;
  end

  // Servo mapping by multiplication with a scaled reciprocal of nine.
  always_comb begin
    clamp1 = (angle1_q < ANGLE_MIN) ? ANGLE_MIN : ((angle1_q > ANGLE_MAX) ? ANGLE_MAX : angle1_q);
    clamp2 = (angle2_q < ANGLE_MIN) ? ANGLE_MIN : ((angle2_q > ANGLE_MAX) ? ANGLE_MAX : angle2_q);
    offset1 = 8'(clamp1 - ANGLE_MIN);
    offset2 = 8'(clamp2 - ANGLE_MIN);
    prod1 = 36'(offset1) * 36'(PULSE_RECIP);
    prod2 = 36'(offset2) * 36'(PULSE_RECIP);
    pulse1_calc = PULSE_MIN + 12'(prod1 >> PULSE_SHIFT);
    pulse2_calc = PULSE_MIN + 12'(prod2 >> PULSE_SHIFT);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= operation;
      angle1_q <= first_angle;
      angle2_q <= second_angle;
      ann_samples_q <= announced_samples;
      ann_frags_q <= announced_fragments;
      frag_num_q <= fragment_number;
      frag_len_q <= fragment_length;
      byte_pos_q <= byte_position;
      sample_q <= sample_byte;
      frag_end_q <= fragment_end;
    end
  end

  // Sample store: one write for fragment bytes, one registered read for ticks.
  always_ff @(posedge clk) begin
    if (store_write) begin
      sample_store[wr_addr] <= sample_q;
    end
    if (cmd.execute && stat.sample_fetch) begin
      rd_data <= sample_store[AW'(play_position)];
    end
  end

  // Receiver state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit <= LIMIT_RESET;
      stored_count <= '0;
      expected_count <= '0;
      received_count <= '0;
      ready_flag <= 1'b0;
      playing_flag <= 1'b0;
      play_position <= '0;
      play_length <= '0;
      pulse_one <= PULSE_CENTER;
      pulse_two <= PULSE_CENTER;
      duty_value <= DUTY_IDLE;
      status_q <= STATUS_OK;
    end else begin
      if (cfg_write) begin
        sample_limit <= cfg_data;
      end
      if (cmd.load_duty) begin
        duty_value <= rd_data;
      end
      if (cmd.execute) begin
        status_q <= STATUS_OK;
        case (op_q)
          OP_SERVO: begin
            pulse_one <= pulse1_calc;
            pulse_two <= pulse2_calc;
          end
          OP_AUDIO_START: begin
            stored_count <= clamped_count;
            expected_count <= ann_frags_q;
            received_count <= '0;
            ready_flag <= 1'b0;
          end
          OP_FRAGMENT: begin
            if (!frag_ok) begin
              status_q <= STATUS_DROPPED;
            end else if (frag_end_q) begin
              received_count <= received_inc;
              if (received_inc >= expected_count) ready_flag <= 1'b1;
            end
          end
          OP_PLAY: begin
            if (play_ok) begin
              play_length <= stored_count;
              play_position <= '0;
              playing_flag <= 1'b1;
              duty_value <= DUTY_IDLE;
            end else begin
              status_q <= STATUS_REFUSED;
            end
          end
          OP_TICK: begin
            if (tick_has_sample) begin
              play_position <= play_position + 17'd1;
            end else if (playing_flag) begin
              duty_value <= DUTY_IDLE;
              playing_flag <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register, loaded once the item has finished.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      first_pulse <= pulse_one;
      second_pulse <= pulse_two;
      speaker_duty <= duty_value;
      is_playing <= playing_flag;
      audio_complete <= ready_flag;
      status <= status_q;
    end
  end

endmodule

// ===== hw/rtl/servo_and_audio_packet_receiver_core.sv =====
// Top level of the servo and audio packet receiver: controller plus datapath.
// Each item is one command: a servo update, an audio start, one fragment byte, a play
// request or a sample tick, and every item returns exactly one result holding both
// pulse widths, the speaker duty, the playing and complete flags and a status code.
// An item passes through capture, execution and result load until its result is
// registered; a tick that plays a sample also passes through a fetch step for the
// registered read of the sample store. The next item is accepted as soon as the
// previous one is loaded into the result register, even if that result is not yet
// taken; a finished item waits in its last step while the result register is still
// full. The sample store holds STORE_DEPTH bytes and has no clearing pass.
module servo_and_audio_packet_receiver_core
  import svapr_pkg::*;
#(
  parameter int STORE_DEPTH = 65536
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [15:0] first_angle,
  input  logic signed [15:0] second_angle,
  input  logic [31:0]        announced_samples,
  input  logic [15:0]        announced_fragments,
  input  logic [15:0]        fragment_number,
  input  logic [7:0]         fragment_length,
  input  logic [7:0]         byte_position,
  input  logic [7:0]         sample_byte,
  input  logic               fragment_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        first_pulse,
  output logic [11:0]        second_pulse,
  output logic [7:0]         speaker_duty,
  output logic               is_playing,
  output logic               audio_complete,
  output logic [1:0]         status
);

  svapr_cmd_t  cmd;
  svapr_stat_t stat;

  // Sequencing of each item.
  svapr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // State, store and result register.
  svapr_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_write           (cfg_write),
    .cfg_data            (cfg_data),
    .operation           (operation),
    .first_angle         (first_angle),
    .second_angle        (second_angle),
    .announced_samples   (announced_samples),
    .announced_fragments (announced_fragments),
    .fragment_number     (fragment_number),
    .fragment_length     (fragment_length),
    .byte_position       (byte_position),
    .sample_byte         (sample_byte),
    .fragment_end        (fragment_end),
    .first_pulse         (first_pulse),
    .second_pulse        (second_pulse),
    .speaker_duty        (speaker_duty),
    .is_playing          (is_playing),
    .audio_complete      (audio_complete),
    .status              (status)
  );

endmodule

// ===== bench/servo_and_audio_packet_receiver_core_tb.sv =====
// Self-checking testbench for the servo and audio packet receiver core.
module servo_and_audio_packet_receiver_core_tb;
  import svapr_pkg::*;

  localparam int STORE_DEPTH = 65536;
  localparam int PULSE_SPAN = 2000;
  localparam int ANGLE_SPAN = 180;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 60;
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_CYCLES = 400;

  // One command item as it is offered on the input channel.
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] first_angle;
    logic signed [15:0] second_angle;
    logic [31:0]        announced_samples;
    logic [15:0]        announced_fragments;
    logic [15:0]        fragment_number;
    logic [7:0]         fragment_length;
    logic [7:0]         byte_position;
    logic [7:0]         sample_byte;
    logic               fragment_end;
  } command_t;

  // One result item as it leaves the output channel.
  typedef struct packed {
    logic [11:0] first_pulse;
    logic [11:0] second_pulse;
    logic [7:0]  speaker_duty;
    logic        is_playing;
    logic        audio_complete;
    logic [1:0]  status;
  } snapshot_t;

  // Tracks servo, recording and playback state and queues the expected results.
  class pulse_audio_tracker;
    int          limit_reg;
    int          stored_count;
    logic [15:0] expected_frags;
    logic [15:0] received_frags;
    bit          ready;
    bit          playing;
    int          play_pos;
    int          play_len;
    logic [11:0] pulse_one;
    logic [11:0] pulse_two;
    logic [7:0]  duty;
    logic [7:0]  samples [STORE_DEPTH];
    bit          written [STORE_DEPTH];
    int          written_prefix;
    snapshot_t   pending_outputs [$];
    int          errors;
    int          checked;
    int          active_items;

    function new();
      limit_reg = LIMIT_RESET;
      stored_count = 0;
      expected_frags = '0;
      received_frags = '0;
      ready = 0;
      playing = 0;
      play_pos = 0;
      play_len = 0;
      pulse_one = PULSE_CENTER;
      pulse_two = PULSE_CENTER;
      duty = DUTY_IDLE;
      written_prefix = 0;
      errors = 0;
      checked = 0;
      active_items = 0;
    endfunction

    function int limit_now();
      return (limit_reg > STORE_DEPTH) ? STORE_DEPTH : limit_reg;
    endfunction

    // A play may only start when every sample it will read has been written.
    function bit play_safe();
      return !(ready && stored_count != 0) || stored_count <= written_prefix;
    endfunction

    function logic [11:0] angle_to_pulse(logic signed [15:0] ang);
      int a;
      a = ang;
      if (a < ANGLE_MIN) a = ANGLE_MIN;
      if (a > ANGLE_MAX) a = ANGLE_MAX;
      return PULSE_MIN + 12'((a - ANGLE_MIN) * PULSE_SPAN / ANGLE_SPAN);
    endfunction

    // Applies one accepted item and queues the result it must produce.
    function void note_item(command_t c);
      int        lim;
      int        base;
      bit        ignored;
      snapshot_t r;
      lim = limit_now();
      ignored = 0;
      r.status = STATUS_OK;
      case (c.operation)
        OP_SERVO: begin
          pulse_one = angle_to_pulse(c.first_angle);
          pulse_two = angle_to_pulse(c.second_angle);
        end
        OP_AUDIO_START: begin
          stored_count = (c.announced_samples < lim) ? int'(c.announced_samples) : lim;
          expected_frags = c.announced_fragments;
          received_frags = '0;
          ready = 0;
        end
        OP_FRAGMENT: begin
          base = int'(c.fragment_number) * int'(CHUNK_BYTES);
          if (c.fragment_length <= CHUNK_BYTES && base + int'(c.fragment_length) <= lim) begin
            if (c.byte_position < c.fragment_length) begin
              samples[base + c.byte_position] = c.sample_byte;
              written[base + c.byte_position] = 1;
              while (written_prefix < STORE_DEPTH && written[written_prefix])
                written_prefix++;
            end
            if (c.fragment_end) begin
              received_frags = received_frags + 16'd1;
              if (received_frags >= expected_frags) ready = 1;
            end
          end else begin
            r.status = STATUS_DROPPED;
          end
        end
        OP_PLAY: begin
          if (ready && stored_count != 0) begin
            play_len = stored_count;
            play_pos = 0;
            playing = 1;
            duty = DUTY_IDLE;
          end else begin
            r.status = STATUS_REFUSED;
          end
        end
        OP_TICK: begin
          if (!playing) begin
            ignored = 1;
          end else if (play_pos < play_len) begin
            duty = samples[play_pos];
            play_pos++;
          end else begin
            duty = DUTY_IDLE;
            playing = 0;
          end
        end
        default: ignored = 1;
      endcase
      r.first_pulse = pulse_one;
      r.second_pulse = pulse_two;
      r.speaker_duty = duty;
      r.is_playing = playing;
      r.audio_complete = ready;
      pending_outputs.push_back(r);
      if (!ignored) active_items++;
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(snapshot_t got);
      snapshot_t want;
      checked++;
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: result with no item outstanding, actual %h", $time, got);
        return;
      end
      want = pending_outputs.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected pulse %0d %0d duty %0d play %0b done %0b status %0d",
                 $time, want.first_pulse, want.second_pulse, want.speaker_duty,
                 want.is_playing, want.audio_complete, want.status);
        $display("%0t:          actual pulse %0d %0d duty %0d play %0b done %0b status %0d",
                 $time, got.first_pulse, got.second_pulse, got.speaker_duty,
                 got.is_playing, got.audio_complete, got.status);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [16:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         operation;
  logic signed [15:0] first_angle;
  logic signed [15:0] second_angle;
  logic [31:0]        announced_samples;
  logic [15:0]        announced_fragments;
  logic [15:0]        fragment_number;
  logic [7:0]         fragment_length;
  logic [7:0]         byte_position;
  logic [7:0]         sample_byte;
  logic               fragment_end;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        first_pulse;
  logic [11:0]        second_pulse;
  logic [7:0]         speaker_duty;
  logic               is_playing;
  logic               audio_complete;
  logic [1:0]         status;

  pulse_audio_tracker tracker = new();
  int cycle_count;
  int burst_left;

  servo_and_audio_packet_receiver_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .first_angle(first_angle),
    .second_angle(second_angle),
    .announced_samples(announced_samples),
    .announced_fragments(announced_fragments),
    .fragment_number(fragment_number),
    .fragment_length(fragment_length),
    .byte_position(byte_position),
    .sample_byte(sample_byte),
    .fragment_end(fragment_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .first_pulse(first_pulse),
    .second_pulse(second_pulse),
    .speaker_duty(speaker_duty),
    .is_playing(is_playing),
    .audio_complete(audio_complete),
    .status(status)
  );

  // Clock with a period of 10.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Command with every field random; callers override what matters.
  function automatic command_t scrambled();
    command_t c;
    c.operation = 3'($urandom);
    c.first_angle = 16'($urandom);
    c.second_angle = 16'($urandom);
    c.announced_samples = $urandom;
    c.announced_fragments = 16'($urandom);
    c.fragment_number = 16'($urandom);
    c.fragment_length = 8'($urandom);
    c.byte_position = 8'($urandom);
    c.sample_byte = 8'($urandom);
    c.fragment_end = 1'($urandom);
    return c;
  endfunction

  // Offers one item in bursts with random gaps, then records it once accepted; an unsafe play is sent as a tick.
  task automatic send(command_t c);
    int gap;
    if (c.operation == OP_PLAY && !tracker.play_safe()) c.operation = OP_TICK;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 0;
      end
    end
    @(negedge clk);
    operation = c.operation;
    first_angle = c.first_angle;
    second_angle = c.second_angle;
    announced_samples = c.announced_samples;
    announced_fragments = c.announced_fragments;
    fragment_number = c.fragment_number;
    fragment_length = c.fragment_length;
    byte_position = c.byte_position;
    sample_byte = c.sample_byte;
    fragment_end = c.fragment_end;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    tracker.note_item(c);
  endtask

  task automatic servo(int a, int b);
    command_t c;
    c = scrambled();
    c.operation = OP_SERVO;
    c.first_angle = a[15:0];
    c.second_angle = b[15:0];
    send(c);
  endtask

  task automatic start(logic [31:0] n, logic [15:0] frags);
    command_t c;
    c = scrambled();
    c.operation = OP_AUDIO_START;
    c.announced_samples = n;
    c.announced_fragments = frags;
    send(c);
  endtask

  task automatic frag(int num, int len, int pos, int value, bit is_last);
    command_t c;
    c = scrambled();
    c.operation = OP_FRAGMENT;
    c.fragment_number = num[15:0];
    c.fragment_length = len[7:0];
    c.byte_position = pos[7:0];
    c.sample_byte = value[7:0];
    c.fragment_end = is_last;
    send(c);
  endtask

  task automatic plain(logic [2:0] op);
    command_t c;
    c = scrambled();
    c.operation = op;
    send(c);
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic settle();
    @(negedge clk);
    in_valid = 0;
    while (tracker.pending_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the sample limit while the block is idle.
  task automatic write_limit(int value);
    settle();
    cfg_write = 1;
    cfg_data = value[16:0];
    @(negedge clk);
    cfg_write = 0;
    tracker.limit_reg = value & 17'h1FFFF;
  endtask

  // Single random item of any kind, mostly malformed or out of place.
  task automatic noise();
    command_t c;
    c = scrambled();
    case ($urandom_range(0, 9))
      0, 1: begin
        c.operation = OP_SERVO;
        if ($urandom_range(0, 1)) begin
          c.first_angle = 16'($urandom_range(0, 200) - 100);
          c.second_angle = 16'($urandom_range(0, 200) - 100);
        end
      end
      2: begin
        c.operation = OP_AUDIO_START;
        if ($urandom_range(0, 1)) begin
          c.announced_samples = $urandom_range(0, 300);
          c.announced_fragments = 16'($urandom_range(0, 3));
        end
      end
      3, 4: begin
        c.operation = OP_FRAGMENT;
        if ($urandom_range(0, 1)) begin
          c.fragment_number = 16'($urandom_range(0, 3));
          c.fragment_length = 8'($urandom_range(0, 210));
          c.byte_position = 8'($urandom_range(0, 210));
        end
      end
      5: c.operation = OP_PLAY;
      6, 7: c.operation = OP_TICK;
      default: c.operation = 3'($urandom_range(5, 7));
    endcase
    send(c);
  endtask

  // Mostly well-formed recording: start, all fragment bytes, play, then ticks, with noise items mixed in.
  task automatic record(int lo, int hi);
    int lim;
    int n;
    int frags;
    int len;
    int ticks;
    lim = tracker.limit_now();
    n = $urandom_range(lo, hi);
    if (lim > 0 && n > lim) n = lim;
    frags = (n + CHUNK_BYTES - 1) / CHUNK_BYTES;
    start(($urandom_range(0, 7) == 0) ? $urandom : n,
          16'(frags + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) - 1 : 0)));
    for (int f = 0; f < frags; f++) begin
      len = (f == frags - 1) ? n - f * CHUNK_BYTES : CHUNK_BYTES;
      for (int p = 0; p < len; p++) begin
        if ($urandom_range(0, 24) == 0) noise();
        frag(f, len, p, $urandom, p == len - 1);
      end
    end
    plain(OP_PLAY);
    ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + 1 + $urandom_range(0, 2);
    repeat (ticks) begin
      if ($urandom_range(0, 19) == 0) noise();
      plain(OP_TICK);
    end
  endtask

  // Random phase: recordings or single noise items, with an occasional settle.
  task automatic run_phase(int target);
    int goal;
    int pick;
    goal = tracker.active_items + target;
    while (tracker.active_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) record(1, ($urandom_range(0, 9) == 0) ? 60 : 12);
      else noise();
      if (pick == 99) settle();
    end
  endtask

  // Receiver: stalls on a rotating pattern, with one long hold-off.
  initial begin
    int rx_cycle;
    bit held;
    out_ready = 0;
    rx_cycle = 0;
    held = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (!held && tracker.checked >= HOLD_AFTER) begin
        held = 1;
        out_ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      case ((rx_cycle / 97) % 4)
        0: out_ready = 1;
        1: out_ready = 1'($urandom_range(0, 1));
        2: out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = rx_cycle[2];
      endcase
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result({first_pulse, second_pulse, speaker_duty, is_playing,
                            audio_complete, status});
  end

  // Timeout.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Main sequence: reset, directed items, then random phases under several limits.
  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_data = '0;
    in_valid = 0;
    burst_left = 0;
    {operation, first_angle, second_angle, announced_samples, announced_fragments,
     fragment_number, fragment_length, byte_position, sample_byte, fragment_end} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    write_limit(LIMIT_RESET);

    // Servo clamping at both extremes and truncation of the mapping.
    servo(-32768, 32767);
    servo(-90, 90);
    servo(-91, 91);
    servo(-89, 1);
    // Tick while idle, play refused, unknown operations.
    plain(OP_TICK);
    plain(OP_PLAY);
    plain(3'd5);
    plain(3'd7);
    // Short recording with a byte past the fragment length.
    start(3, 1);
    frag(0, 3, 0, 8'hFF, 0);
    frag(0, 3, 5, 8'h11, 0);
    frag(0, 3, 1, 8'h00, 0);
    frag(0, 3, 2, 8'h5A, 1);
    // Oversized fragment and fragment beyond the limit are dropped.
    frag(0, 201, 0, 8'h22, 1);
    frag(65535, 1, 0, 8'h33, 1);
    // Playback, restart during playback, and an audio start while playing.
    plain(OP_PLAY);
    plain(OP_TICK);
    plain(OP_TICK);
    plain(OP_PLAY);
    plain(OP_TICK);
    start(2, 1);
    plain(OP_TICK);
    plain(OP_TICK);
    plain(OP_TICK);
    // Sample count clamped to the limit; a zero-length fragment still counts.
    start(32'hFFFF_FFFF, 0);
    frag(0, 0, 0, 8'h44, 1);
    run_phase(PHASE_ITEMS);

    write_limit(65536);
    record(201, 230);
    run_phase(PHASE_ITEMS);
    write_limit(0);
    run_phase(PHASE_ITEMS);
    write_limit(1);
    run_phase(PHASE_ITEMS);
    write_limit(65535);
    run_phase(PHASE_ITEMS);
    write_limit($urandom_range(1, 65536));
    run_phase(PHASE_ITEMS);

    settle();
    if (tracker.errors == 0 && tracker.pending_outputs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== servo_and_audio_packet_receiver_core.f =====
hw/rtl/svapr_pkg.sv
hw/rtl/svapr_ctrl.sv
hw/rtl/svapr_dpath.sv
hw/rtl/servo_and_audio_packet_receiver_core.sv
bench/servo_and_audio_packet_receiver_core_tb.sv
